>>> hdl/rv32id_pkg.sv
// shared types, codes and lookup functions for the rv32i instruction decoder
package rv32id_pkg;

	// major opcodes of the rv32i base set
	localparam logic [6:0] OPC_REG    = 7'h33;
	localparam logic [6:0] OPC_IMM    = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;

	// funct7 values that select the base and alternate operations
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// funct3 codes that need special handling
	localparam logic [2:0] F3_ADD_SUB = 3'd0;
	localparam logic [2:0] F3_SHR     = 3'd5;

	// low immediate bits cleared for the u format
	localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

	typedef enum logic [2:0] {
		FMT_NONE = 3'd0,
		FMT_R    = 3'd1,
		FMT_I    = 3'd2,
		FMT_S    = 3'd3,
		FMT_B    = 3'd4,
		FMT_U    = 3'd5,
		FMT_J    = 3'd6
	} fmt_t;

	typedef enum logic [5:0] {
		ID_UNKNOWN = 6'd0,
		ID_ADD   = 6'd1,  ID_SLL   = 6'd2,  ID_SLT   = 6'd3,  ID_SLTU  = 6'd4,
		ID_XOR   = 6'd5,  ID_SRL   = 6'd6,  ID_OR    = 6'd7,  ID_AND   = 6'd8,
		ID_SUB   = 6'd9,  ID_SRA   = 6'd10,
		ID_ADDI  = 6'd11, ID_SLTI  = 6'd12, ID_SLTIU = 6'd13, ID_XORI  = 6'd14,
		ID_ORI   = 6'd15, ID_ANDI  = 6'd16,
		ID_SLLI  = 6'd17, ID_SRLI  = 6'd18, ID_SRAI  = 6'd19,
		ID_LB    = 6'd20, ID_LH    = 6'd21, ID_LW    = 6'd22, ID_LBU   = 6'd23,
		ID_LHU   = 6'd24,
		ID_SB    = 6'd25, ID_SH    = 6'd26, ID_SW    = 6'd27,
		ID_BEQ   = 6'd28, ID_BNE   = 6'd29, ID_BLT   = 6'd30, ID_BGE   = 6'd31,
		ID_BLTU  = 6'd32, ID_BGEU  = 6'd33,
		ID_LUI   = 6'd34, ID_AUIPC = 6'd35, ID_JAL   = 6'd36, ID_JALR  = 6'd37
	} instr_id_t;

	// one decoded item
	typedef struct packed {
		logic [6:0]         major_opcode;
		logic [4:0]         dest_reg;
		logic [2:0]         minor_func;
		logic [4:0]         src_reg_a;
		logic [4:0]         src_reg_b;
		logic [6:0]         upper_func;
		fmt_t               format_class;
		logic signed [31:0] immediate;
		instr_id_t          instr_id;
	} dec_result_t;

	// register-register ops with base funct7
	function automatic instr_id_t id_reg_base(input logic [2:0] f3);
		instr_id_t id;
		unique case (f3)
			3'd0:    id = ID_ADD;
			3'd1:    id = ID_SLL;
			3'd2:    id = ID_SLT;
			3'd3:    id = ID_SLTU;
			3'd4:    id = ID_XOR;
			3'd5:    id = ID_SRL;
			3'd6:    id = ID_OR;
			default: id = ID_AND;
		endcase
		return id;
	endfunction

	// register-immediate ops other than right shifts
	function automatic instr_id_t id_imm(input logic [2:0] f3);
		instr_id_t id;
		unique case (f3)
			3'd0:    id = ID_ADDI;
			3'd1:    id = ID_SLLI;
			3'd2:    id = ID_SLTI;
			3'd3:    id = ID_SLTIU;
			3'd4:    id = ID_XORI;
			3'd6:    id = ID_ORI;
			3'd7:    id = ID_ANDI;
			default: id = ID_UNKNOWN;
		endcase
		return id;
	endfunction

	// loads
	function automatic instr_id_t id_load(input logic [2:0] f3);
		instr_id_t id;
		unique case (f3)
			3'd0:    id = ID_LB;
			3'd1:    id = ID_LH;
			3'd2:    id = ID_LW;
			3'd4:    id = ID_LBU;
			3'd5:    id = ID_LHU;
			default: id = ID_UNKNOWN;
		endcase
		return id;
	endfunction

	// stores
	function automatic instr_id_t id_store(input logic [2:0] f3);
		instr_id_t id;
		unique case (f3)
			3'd0:    id = ID_SB;
			3'd1:    id = ID_SH;
			3'd2:    id = ID_SW;
			default: id = ID_UNKNOWN;
		endcase
		return id;
	endfunction

	// conditional branches
	function automatic instr_id_t id_branch(input logic [2:0] f3);
		instr_id_t id;
		unique case (f3)
			3'd0:    id = ID_BEQ;
			3'd1:    id = ID_BNE;
			3'd4:    id = ID_BLT;
			3'd5:    id = ID_BGE;
			3'd6:    id = ID_BLTU;
			3'd7:    id = ID_BGEU;
			default: id = ID_UNKNOWN;
		endcase
		return id;
	endfunction

endpackage

>>> hdl/rv32id_if.sv
// valid/ready channel interfaces for instruction words and decoded items

interface rv32id_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;

	modport source (output valid, output instr_word, input ready);
	modport sink (input valid, input instr_word, output ready);
endinterface

interface rv32id_dec_if;
	logic               valid;
	logic               ready;
	logic [6:0]         major_opcode;
	logic [4:0]         dest_reg;
	logic [2:0]         minor_func;
	logic [4:0]         src_reg_a;
	logic [4:0]         src_reg_b;
	logic [6:0]         upper_func;
	logic [2:0]         format_class;
	logic signed [31:0] immediate;
	logic [5:0]         instr_id;

	modport source (
		output valid, output major_opcode, output dest_reg, output minor_func,
		output src_reg_a, output src_reg_b, output upper_func, output format_class,
		output immediate, output instr_id, input ready
	);
	modport sink (
		input valid, input major_opcode, input dest_reg, input minor_func,
		input src_reg_a, input src_reg_b, input upper_func, input format_class,
		input immediate, input instr_id, output ready
	);
endinterface

>>> hdl/rv32id_decode.sv
// combinational field split, format class, immediate and identity decode
module rv32id_decode (
	input  logic [31:0]                instr_word,
	output rv32id_pkg::dec_result_t    result
);
	import rv32id_pkg::*;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_u;
	logic [31:0] imm_j;

	assign opc = instr_word[6:0];
	assign f3  = instr_word[14:12];
	assign f7  = instr_word[31:25];

	// immediates of every format, sign extended from bit 31
	assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
	assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
	assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
		instr_word[30:25], instr_word[11:8], 1'b0};
	assign imm_u = instr_word & UPPER_MASK;
	assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
		instr_word[20], instr_word[30:21], 1'b0};

	// raw fields pass straight through, opcode selects format, immediate and identity
	always_comb begin
		result.major_opcode = opc;
		result.dest_reg     = instr_word[11:7];
		result.minor_func   = f3;
		result.src_reg_a    = instr_word[19:15];
		result.src_reg_b    = instr_word[24:20];
		result.upper_func   = f7;
		result.format_class = FMT_NONE;
		result.immediate    = '0;
		result.instr_id     = ID_UNKNOWN;
		unique case (opc)
			OPC_REG: begin
				result.format_class = FMT_R;
				if (f7 == F7_BASE) begin
					result.instr_id = id_reg_base(f3);
				end else if (f7 == F7_ALT) begin
					if (f3 == F3_ADD_SUB) begin
						result.instr_id = ID_SUB;
					end else if (f3 == F3_SHR) begin
						result.instr_id = ID_SRA;
					end
				end
			end
			OPC_IMM: begin
				result.format_class = FMT_I;
				result.immediate    = imm_i;
				if (f3 == F3_SHR) begin
					if (f7 == F7_BASE) begin
						result.instr_id = ID_SRLI;
					end else if (f7 == F7_ALT) begin
						result.instr_id = ID_SRAI;
					end
				end else begin
					result.instr_id = id_imm(f3);
				end
			end
			OPC_LOAD: begin
				result.format_class = FMT_I;
				result.immediate    = imm_i;
				result.instr_id     = id_load(f3);
			end
			OPC_STORE: begin
				result.format_class = FMT_S;
				result.immediate    = imm_s;
				result.instr_id     = id_store(f3);
			end
			OPC_BRANCH: begin
				result.format_class = FMT_B;
				result.immediate    = imm_b;
				result.instr_id     = id_branch(f3);
			end
			OPC_LUI: begin
				result.format_class = FMT_U;
				result.immediate    = imm_u;
				result.instr_id     = ID_LUI;
			end
			OPC_AUIPC: begin
				result.format_class = FMT_U;
				result.immediate    = imm_u;
				result.instr_id     = ID_AUIPC;
			end
			OPC_JAL: begin
				result.format_class = FMT_J;
				result.immediate    = imm_j;
				result.instr_id     = ID_JAL;
			end
			OPC_JALR: begin
				result.format_class = FMT_I;
				result.immediate    = imm_i;
				result.instr_id     = ID_JALR;
			end
			default: begin
				result.format_class = FMT_NONE;
			end
		endcase
	end

endmodule

>>> hdl/rv32i_instruction_decoder.sv
// rv32i instruction decoder top level: input register, decode, result register
// pipeline: two register stages; an accepted item is held in the input register,
// decoded, then shown from the result register; one item per cycle while the
// output is ready, and the input register also loads whenever it is empty
// reset: arst_n clears both stage valid flags, so no item is shown after reset
module rv32i_instruction_decoder (
	input  logic              clk,
	input  logic              arst_n,
	rv32id_instr_if.sink      instr,
	rv32id_dec_if.source      decoded
);
	import rv32id_pkg::*;

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	dec_result_t result_s2;
	dec_result_t dec_result;
	logic        adv_s2;
	logic        in_take;

	// stage two loads when empty or when its item leaves
	assign adv_s2   = !valid_s2 || decoded.ready;
	assign instr.ready = !valid_s1 || adv_s2;
	assign in_take  = instr.valid && instr.ready;

	// stage one: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			instr_s1 <= instr.instr_word;
		end
	end

	rv32id_decode u_decode (
		.instr_word (instr_s1),
		.result     (dec_result)
	);

	// stage two: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= dec_result;
		end
	end

	// output channel
	assign decoded.valid        = valid_s2;
	assign decoded.major_opcode = result_s2.major_opcode;
	assign decoded.dest_reg     = result_s2.dest_reg;
	assign decoded.minor_func   = result_s2.minor_func;
	assign decoded.src_reg_a    = result_s2.src_reg_a;
	assign decoded.src_reg_b    = result_s2.src_reg_b;
	assign decoded.upper_func   = result_s2.upper_func;
	assign decoded.format_class = 3'(result_s2.format_class);
	assign decoded.immediate    = result_s2.immediate;
	assign decoded.instr_id     = 6'(result_s2.instr_id);

endmodule

>>> hdl/rv32id_checker.sv
// port-level checker for the rv32i instruction decoder and its bind
module rv32id_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [6:0]         major_opcode,
	input logic [2:0]         format_class,
	input logic signed [31:0] immediate,
	input logic [5:0]         instr_id
);
	import rv32id_pkg::*;

	// a stalled item stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("decoded item dropped while stalled");

	// a stalled item keeps its identity and immediate
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(instr_id) && $stable(immediate))
		else $error("decoded item changed while stalled");

	// a known identity always comes with a known format
	a_id_has_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && instr_id != 6'(ID_UNKNOWN) |-> format_class != 3'(FMT_NONE))
		else $error("identity given without format class");

	// register and unknown formats carry no immediate
	a_no_imm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (format_class == 3'(FMT_R) || format_class == 3'(FMT_NONE))
		|-> immediate == 32'sd0)
		else $error("immediate set for r-type or unknown word");

	// upper immediates come only from lui and auipc and have clear low bits
	a_upper_imm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_class == 3'(FMT_U)
		|-> immediate[11:0] == 12'd0
			&& (major_opcode == OPC_LUI || major_opcode == OPC_AUIPC))
		else $error("bad u-format item");

endmodule

bind rv32i_instruction_decoder rv32id_checker u_rv32id_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (decoded.valid),
	.out_ready    (decoded.ready),
	.major_opcode (decoded.major_opcode),
	.format_class (decoded.format_class),
	.immediate    (decoded.immediate),
	.instr_id     (decoded.instr_id)
);
